### hdl/dehs_pkg.sv
// Package for the drive enable and homing sequencer.
// Holds the opcode codes, drive control word constants and the item and result types.
// Used by every module of the block.
package dehs_pkg;

  typedef enum logic [2:0] {
    OP_POLL    = 3'd0,
    OP_MOVE    = 3'd1,
    OP_STOP    = 3'd2,
    OP_CONNECT = 3'd3,
    OP_QUERY   = 3'd4
  } opcode_e;

  localparam logic [2:0] RegHomingMask = 3'd0;
  localparam logic [3:0] HomingMaskRst = 4'h3;

  localparam logic [15:0] CwShutdown   = 16'h0006;
  localparam logic [15:0] CwSwitchOn   = 16'h0007;
  localparam logic [15:0] CwEnableOp   = 16'h000F;
  localparam logic [15:0] CwQuickStop  = 16'h000B;
  localparam logic [15:0] CwFaultReset = 16'h0086;
  localparam logic [15:0] CwRunIdle    = 16'h002F;
  localparam logic [15:0] CwSetpoint   = 16'h003F;

  localparam logic [15:0] SwOpEnMask    = 16'h0067;
  localparam logic [15:0] SwOpEnValue   = 16'h0027;
  localparam logic [15:0] SwHomeMask    = 16'h3400;
  localparam logic [15:0] SwHomeDone    = 16'h1400;
  localparam logic [15:0] SwHomeError   = 16'h2000;
  localparam logic [15:0] SwReadyMask   = 16'h006F;
  localparam logic [15:0] SwReadyValue  = 16'h0021;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         axis;
    logic [15:0]        status_word;
    logic signed [31:0] target_position;
  } item_t;

  typedef struct packed {
    logic [1:0]         axis_out;
    logic [15:0]        control_word;
    logic               operation_enabled;
    logic               target_reached;
    logic               homing_pending;
    logic               homing_finished;
    logic               position_write;
    logic signed [31:0] target_out;
  } result_t;

  typedef struct packed {
    logic       load;
    logic [3:0] mask;
  } cfg_load_t;

endpackage

### hdl/drive_enable_and_homing_sequencer.sv
// Top level of the drive enable and homing sequencer: input register, result register
// and configuration port around the per-axis state. Depends on dehs_pkg,
// dehs_cfg_regs and dehs_axis_state.
//
// Each transaction carries an opcode for one axis and yields exactly one result, through
// the input and then the result register. A new transaction is taken every cycle while
// the output is not stalled: the input register feeds update logic that writes the axis
// state and the result register at the same edge, so the next transaction already sees
// the updated state. Writing homing_mask reloads the homing flags of all axes and
// restarts their homing steps; write it only while no transaction is in flight.
module drive_enable_and_homing_sequencer import dehs_pkg::*; #(
  parameter int AXES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [1:0]         axis_i,
  input  logic [15:0]        status_word_i,
  input  logic signed [31:0] target_position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         axis_out_o,
  output logic [15:0]        control_word_o,
  output logic               operation_enabled_o,
  output logic               target_reached_o,
  output logic               homing_pending_o,
  output logic               homing_finished_o,
  output logic               position_write_o,
  output logic signed [31:0] target_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic      in_valid_q;
  item_t     item_q;
  logic      out_valid_q;
  result_t   result_q;
  result_t   result_d;
  logic      advance;
  cfg_load_t cfg_load;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign pready     = 1'b1;

  dehs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg_load)
  );

  dehs_axis_state #(
    .AXES (AXES)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg_load),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.opcode          <= opcode_i;
      item_q.axis            <= axis_i;
      item_q.status_word     <= status_word_i;
      item_q.target_position <= target_position_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign axis_out_o          = result_q.axis_out;
  assign control_word_o      = result_q.control_word;
  assign operation_enabled_o = result_q.operation_enabled;
  assign target_reached_o    = result_q.target_reached;
  assign homing_pending_o    = result_q.homing_pending;
  assign homing_finished_o   = result_q.homing_finished;
  assign position_write_o    = result_q.position_write;
  assign target_out_o        = result_q.target_out;

endmodule

### hdl/dehs_cfg_regs.sv
// Configuration register file of the sequencer, reached over an APB-style port.
// Holds the homing mask and signals a reload of the homing state on each write to it.
// Depends on dehs_pkg.
module dehs_cfg_regs import dehs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_load_t   cfg_o
);

  logic [3:0] mask_q;
  logic       wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == RegHomingMask[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= HomingMaskRst;
    end else if (wr_en) begin
      mask_q <= pwdata[3:0];
    end
  end

  assign prdata    = (paddr[2] == RegHomingMask[2]) ? {28'd0, mask_q} : 32'd0;
  assign cfg_o.load = wr_en;
  assign cfg_o.mask = pwdata[3:0];

endmodule

### hdl/dehs_axis_state.sv
// Per-axis state of the sequencer and the combinational update for one transaction.
// Produces the result of the transaction from the state it leaves behind.
// Depends on dehs_pkg.
module dehs_axis_state import dehs_pkg::*; #(
  parameter int AXES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  item_t     item_i,
  input  cfg_load_t cfg_i,
  output result_t   result_o
);

  localparam int IdxW = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [1:0] {
    PH_ENABLE = 2'd0,
    PH_HOMING = 2'd1,
    PH_SETTLE = 2'd2
  } phase_e;

  logic [15:0] control_q [AXES];
  logic [15:0] status_q  [AXES];
  phase_e      phase_q   [AXES];
  logic [AXES-1:0] needs_q;
  logic [AXES-1:0] pend_q;
  logic [AXES-1:0] conn_q;

  logic [IdxW-1:0] idx;
  logic            in_range;
  logic [15:0]     ctl_d;
  logic [15:0]     sts_d;
  phase_e          ph_d;
  logic            needs_d;
  logic            pend_d;
  logic            conn_d;
  logic            finished;
  logic            op_en;
  logic            pos_wr;

  function automatic logic [15:0] enable_rules(logic [15:0] cw, logic [15:0] s);
    logic [15:0] r;
    r = cw;
    if (s[6]) begin
      r = CwShutdown;
    end else if (s[5]) begin
      r = s[1] ? CwEnableOp : CwSwitchOn;
    end
    return r;
  endfunction

  assign idx      = IdxW'(item_i.axis);
  assign in_range = (32'(item_i.axis) < AXES);

  always_comb begin
    ctl_d    = control_q[idx];
    sts_d    = status_q[idx];
    ph_d     = phase_q[idx];
    needs_d  = needs_q[idx];
    pend_d   = pend_q[idx];
    conn_d   = conn_q[idx];
    finished = 1'b0;
    pos_wr   = 1'b0;
    op_en    = ((item_i.status_word & SwOpEnMask) == SwOpEnValue);
    unique case (item_i.opcode)
      OP_POLL: begin
        sts_d = item_i.status_word;
        if (conn_d) begin
          if (needs_d) begin
            unique case (ph_d)
              PH_ENABLE: begin
                ctl_d = enable_rules(ctl_d, item_i.status_word);
                if (op_en) begin
                  ctl_d = CwSetpoint;
                  ph_d  = PH_HOMING;
                end
              end
              PH_HOMING: begin
                if ((item_i.status_word & SwHomeMask) == SwHomeDone) begin
                  ctl_d = CwShutdown;
                  ph_d  = PH_SETTLE;
                end else if ((item_i.status_word & SwHomeMask) == SwHomeError) begin
                  ctl_d = CwShutdown;
                  ph_d  = PH_ENABLE;
                end
              end
              PH_SETTLE: begin
                if ((item_i.status_word & SwReadyMask) == SwReadyValue) begin
                  needs_d  = 1'b0;
                  ph_d     = PH_ENABLE;
                  finished = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end else begin
            ctl_d = enable_rules(ctl_d, item_i.status_word);
            if (op_en) begin
              if (pend_d) begin
                ctl_d  = CwSetpoint;
                pend_d = 1'b0;
              end else begin
                ctl_d = CwRunIdle;
              end
            end
          end
        end
      end
      OP_MOVE: begin
        ctl_d  = CwSetpoint;
        pend_d = 1'b1;
        pos_wr = 1'b1;
      end
      OP_STOP: begin
        ctl_d = CwQuickStop;
      end
      OP_CONNECT: begin
        conn_d = 1'b1;
        ctl_d  = CwFaultReset;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o          = '0;
    result_o.axis_out = item_i.axis;
    if (in_range) begin
      result_o.control_word      = ctl_d;
      result_o.operation_enabled = ((sts_d & SwOpEnMask) == SwOpEnValue);
      result_o.target_reached    = sts_d[10];
      result_o.homing_pending    = needs_d;
      result_o.homing_finished   = finished;
      result_o.position_write    = pos_wr;
      result_o.target_out        = pos_wr ? item_i.target_position : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        control_q[a] <= '0;
        status_q[a]  <= '0;
        phase_q[a]   <= PH_ENABLE;
        needs_q[a]   <= (a < 4) ? HomingMaskRst[a % 4] : 1'b0;
        pend_q[a]    <= 1'b0;
        conn_q[a]    <= 1'b0;
      end
    end else if (cfg_i.load) begin
      for (int a = 0; a < AXES; a++) begin
        phase_q[a] <= PH_ENABLE;
        needs_q[a] <= (a < 4) ? cfg_i.mask[a % 4] : 1'b0;
      end
    end else if (fire_i && in_range) begin
      control_q[idx] <= ctl_d;
      status_q[idx]  <= sts_d;
      phase_q[idx]   <= ph_d;
      needs_q[idx]   <= needs_d;
      pend_q[idx]    <= pend_d;
      conn_q[idx]    <= conn_d;
    end
  end

endmodule

### dv/drive_enable_and_homing_sequencer_test.sv
// Self-checking testbench for drive_enable_and_homing_sequencer: directed and random
// transactions, APB writes of homing_mask, and a transaction-level predictor of every axis.
// Depends on dehs_pkg and the RTL of the block.
module drive_enable_and_homing_sequencer_test;
  import dehs_pkg::*;

  typedef enum logic [1:0] {
    HOME_ENABLE,
    HOME_START,
    HOME_WAIT_READY,
    HOME_SPARE
  } home_step_e;

  localparam int NumAxes = 4;
  localparam logic [2:0] MaskAddr = 3'(RegHomingMask * 4);
  localparam logic [2:0] UnusedRegAddr = 3'd4;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         opcode_i = '0;
  logic [1:0]         axis_i = '0;
  logic [15:0]        status_word_i = '0;
  logic signed [31:0] target_position_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         axis_out_o;
  logic [15:0]        control_word_o;
  logic               operation_enabled_o;
  logic               target_reached_o;
  logic               homing_pending_o;
  logic               homing_finished_o;
  logic               position_write_o;
  logic signed [31:0] target_out_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  drive_enable_and_homing_sequencer #(.AXES(NumAxes)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .axis_i             (axis_i),
    .status_word_i      (status_word_i),
    .target_position_i  (target_position_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .axis_out_o         (axis_out_o),
    .control_word_o     (control_word_o),
    .operation_enabled_o(operation_enabled_o),
    .target_reached_o   (target_reached_o),
    .homing_pending_o   (homing_pending_o),
    .homing_finished_o  (homing_finished_o),
    .position_write_o   (position_write_o),
    .target_out_o       (target_out_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  logic [15:0] ctrl_word [NumAxes];
  logic [15:0] last_status [NumAxes];
  home_step_e  home_step [NumAxes];
  logic        home_due [NumAxes];
  logic        move_armed [NumAxes];
  logic        linked [NumAxes];
  logic [3:0]  mask_shadow;

  item_t   pending_items [$];
  result_t drive_reports [$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    rx_hold = 1'b0;
  int      mismatches = 0;
  int      items_taken = 0;
  int      reports_seen = 0;
  int      homings_done = 0;
  int      mask_writes = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("drive_enable_and_homing_sequencer verification failed");
    $finish;
  end

  function automatic void load_homing_mask(logic [3:0] m);
    mask_shadow = m;
    for (int a = 0; a < NumAxes; a++) begin
      home_due[a] = m[a];
      home_step[a] = HOME_ENABLE;
    end
  endfunction

  function automatic logic op_enabled(logic [15:0] s);
    return (s & SwOpEnMask) == SwOpEnValue;
  endfunction

  function automatic void apply_enable_rules(int a, logic [15:0] s);
    if (s[6]) begin
      ctrl_word[a] = CwShutdown;
    end else if (s[5]) begin
      ctrl_word[a] = s[1] ? CwEnableOp : CwSwitchOn;
    end
  endfunction

  function automatic logic advance_homing(int a, logic [15:0] s);
    logic done;
    done = 1'b0;
    case (home_step[a])
      HOME_ENABLE: begin
        apply_enable_rules(a, s);
        if (op_enabled(s)) begin
          ctrl_word[a] = CwSetpoint;
          home_step[a] = HOME_START;
        end
      end
      HOME_START: begin
        if ((s & SwHomeMask) == SwHomeDone) begin
          ctrl_word[a] = CwShutdown;
          home_step[a] = HOME_WAIT_READY;
        end else if ((s & SwHomeMask) == SwHomeError) begin
          ctrl_word[a] = CwShutdown;
          home_step[a] = HOME_ENABLE;
        end
      end
      HOME_WAIT_READY: begin
        if ((s & SwReadyMask) == SwReadyValue) begin
          home_due[a] = 1'b0;
          home_step[a] = HOME_ENABLE;
          done = 1'b1;
        end
      end
      default: ;
    endcase
    return done;
  endfunction

  function automatic void advance_running(int a, logic [15:0] s);
    apply_enable_rules(a, s);
    if (op_enabled(s)) begin
      if (move_armed[a]) begin
        ctrl_word[a] = CwSetpoint;
        move_armed[a] = 1'b0;
      end else begin
        ctrl_word[a] = CwRunIdle;
      end
    end
  endfunction

  function automatic result_t sequence_item(item_t it);
    result_t r;
    int a;
    r = '0;
    a = it.axis;
    r.axis_out = it.axis;
    case (it.opcode)
      OP_POLL: begin
        last_status[a] = it.status_word;
        if (linked[a]) begin
          if (home_due[a]) begin
            r.homing_finished = advance_homing(a, it.status_word);
          end else begin
            advance_running(a, it.status_word);
          end
        end
      end
      OP_MOVE: begin
        ctrl_word[a] = CwSetpoint;
        move_armed[a] = 1'b1;
        r.position_write = 1'b1;
        r.target_out = it.target_position;
      end
      OP_STOP: begin
        ctrl_word[a] = CwQuickStop;
      end
      OP_CONNECT: begin
        linked[a] = 1'b1;
        ctrl_word[a] = CwFaultReset;
      end
      default: ;
    endcase
    r.control_word = ctrl_word[a];
    r.operation_enabled = op_enabled(last_status[a]);
    r.target_reached = last_status[a][10];
    r.homing_pending = home_due[a];
    if (r.homing_finished) homings_done++;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : feed
    item_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        drive_reports.push_back(sequence_item({opcode_i, axis_i, status_word_i,
                                               target_position_i}));
        items_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          opcode_i <= nxt.opcode;
          axis_i <= nxt.axis;
          status_word_i <= nxt.status_word;
          target_position_i <= nxt.target_position;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {axis_out_o, control_word_o, operation_enabled_o, target_reached_o,
               homing_pending_o, homing_finished_o, position_write_o, target_out_o};
        reports_seen++;
        if (drive_reports.size() == 0) begin
          flag_mismatch("transaction with nothing predicted, axis", 32'hx,
                        32'(got.axis_out));
        end else begin
          want = drive_reports.pop_front();
          if (got.axis_out !== want.axis_out)
            flag_mismatch("axis_out", 32'(want.axis_out), 32'(got.axis_out));
          if (got.control_word !== want.control_word)
            flag_mismatch("control_word", 32'(want.control_word), 32'(got.control_word));
          if (got.operation_enabled !== want.operation_enabled)
            flag_mismatch("operation_enabled", 32'(want.operation_enabled),
                          32'(got.operation_enabled));
          if (got.target_reached !== want.target_reached)
            flag_mismatch("target_reached", 32'(want.target_reached),
                          32'(got.target_reached));
          if (got.homing_pending !== want.homing_pending)
            flag_mismatch("homing_pending", 32'(want.homing_pending),
                          32'(got.homing_pending));
          if (got.homing_finished !== want.homing_finished)
            flag_mismatch("homing_finished", 32'(want.homing_finished),
                          32'(got.homing_finished));
          if (got.position_write !== want.position_write)
            flag_mismatch("position_write", 32'(want.position_write),
                          32'(got.position_write));
          if (got.target_out !== want.target_out)
            flag_mismatch("target_out", want.target_out, got.target_out);
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic add_item(logic [2:0] op, logic [1:0] ax, logic [15:0] sw,
                          logic [31:0] tp);
    pending_items.push_back({op, ax, sw, tp});
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || drive_reports.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == MaskAddr) begin
      load_homing_mask(data[3:0]);
      mask_writes++;
    end
  endtask

  task automatic check_mask_readback();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MaskAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {28'b0, mask_shadow}) flag_mismatch("homing_mask readback",
                                                       {28'b0, mask_shadow}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] random_status();
    logic [15:0] s;
    s = 16'($urandom());
    case ($urandom_range(0, 7))
      0, 1: s = (s & ~SwOpEnMask) | SwOpEnValue;
      2: s = (s & ~SwHomeMask) | SwHomeDone;
      3: s = (s & ~SwHomeMask) | SwHomeError;
      4: s = (s & ~SwReadyMask) | SwReadyValue;
      5: s[6] = 1'b1;
      6: begin
        s[6] = 1'b0;
        s[5] = 1'b1;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] random_target();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_random_items(int count);
    int pick;
    logic [1:0] ax;
    logic [2:0] op;
    @(negedge clk_i);
    while (count > 0) begin
      pick = $urandom_range(0, 99);
      ax = 2'($urandom_range(0, 3));
      if (pick < 15) begin
        add_item(OP_CONNECT, ax, 16'($urandom()), $urandom());
        add_item(OP_POLL, ax, (random_status() & ~SwOpEnMask) | SwOpEnValue, $urandom());
        add_item(OP_POLL, ax, (random_status() & ~SwHomeMask) | SwHomeDone, $urandom());
        add_item(OP_POLL, ax, (random_status() & ~SwReadyMask) | SwReadyValue, $urandom());
        count -= 4;
      end else if (pick < 25) begin
        add_item(OP_MOVE, ax, 16'($urandom()), random_target());
        add_item(OP_POLL, ax, (random_status() & ~SwOpEnMask) | SwOpEnValue, $urandom());
        count -= 2;
      end else begin
        pick = $urandom_range(0, 99);
        op = pick < 55 ? OP_POLL : pick < 70 ? OP_MOVE : pick < 78 ? OP_STOP :
             pick < 88 ? OP_CONNECT : 3'($urandom_range(4, 7));
        add_item(op, ax, random_status(), random_target());
        count--;
      end
    end
  endtask

  initial begin : stimulus
    int stall_pct [4];
    int idle_pct [4];
    logic [3:0] mask;
    stall_pct = '{0, 0, 49, 30};
    idle_pct = '{0, 49, 0, 30};
    for (int a = 0; a < NumAxes; a++) begin
      ctrl_word[a] = '0;
      last_status[a] = '0;
      move_armed[a] = 1'b0;
      linked[a] = 1'b0;
    end
    load_homing_mask(HomingMaskRst);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_mask_readback();

    @(negedge clk_i);
    add_item(OP_QUERY, 2'd0, 16'h0000, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h0027, 32'h0);
    add_item(OP_CONNECT, 2'd0, 16'h0000, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h0027, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h1427, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h0021, 32'h0);
    add_item(OP_MOVE, 2'd0, 16'h0000, 32'h7FFF_FFFF);
    add_item(OP_POLL, 2'd0, 16'h0427, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h0027, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h0040, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h0022, 32'h0);
    add_item(OP_POLL, 2'd0, 16'h0020, 32'h0);
    add_item(OP_STOP, 2'd0, 16'h0000, 32'h0);
    for (int op = 4; op < 8; op++) add_item(3'(op), 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(OP_CONNECT, 2'd1, 16'h0000, 32'h0);
    add_item(OP_POLL, 2'd1, 16'h0027, 32'h0);
    add_item(OP_POLL, 2'd1, 16'h3427, 32'h0);
    add_item(OP_POLL, 2'd1, 16'h2000, 32'h0);
    add_item(OP_POLL, 2'd2, 16'hFFFF, 32'h0);
    add_item(OP_CONNECT, 2'd3, 16'h0000, 32'h0);
    add_item(OP_MOVE, 2'd3, 16'h0000, 32'h8000_0000);
    add_item(OP_POLL, 2'd3, 16'hFFFF, 32'h0);
    add_item(OP_POLL, 2'd3, 16'h0000, 32'h0);
    drain();

    apb_write(UnusedRegAddr, 32'hFFFF_FFFF);
    check_mask_readback();

    for (int p = 0; p < 4; p++) begin
      mask = p == 0 ? 4'hF : p == 1 ? 4'h0 : 4'($urandom_range(0, 15));
      apb_write(MaskAddr, {28'($urandom_range(0, 32'h0FFF_FFFF)), mask});
      check_mask_readback();
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      queue_random_items(460);
      if (p == 0) begin
        @(posedge clk_i);
        rx_hold <= 1'b1;
        repeat (120) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d transactions and %0d results over %0d homing_mask settings,",
             items_taken, reports_seen, mask_writes);
    $display("four pacing phases and a long output stall; %0d homing runs completed.",
             homings_done);
    if (mismatches == 0) begin
      $display("drive_enable_and_homing_sequencer verification clean");
    end else begin
      $display("drive_enable_and_homing_sequencer verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/dehs_pkg.sv
hdl/dehs_cfg_regs.sv
hdl/dehs_axis_state.sv
hdl/drive_enable_and_homing_sequencer.sv
dv/drive_enable_and_homing_sequencer_test.sv
